### rtl/lprl_pkg.sv
// Shared constants, types and helpers for the longest-prefix route lookup block.
package lprl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int PORT_W      = 8;
    localparam int LEN_W       = $clog2(ADDR_W + 1);

    // Operation codes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_CLEARED  = 3'd4;

    // Search beat that walks down the cell chain, carrying the best match so far
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] mask;
    } search_t;

    // Write bus broadcast to every cell
    typedef struct packed {
        logic              en;
        logic              clear;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
    } wr_t;

endpackage

### rtl/lprl_cell.sv
// One route table cell: holds one entry and refines the passing search beat.
module lprl_cell
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lprl_pkg::IDX_W-1:0]  cell_index,
    input  lprl_pkg::wr_t               wr,
    input  lprl_pkg::search_t           srch_in,
    output lprl_pkg::search_t           srch_out
);
    import lprl_pkg::*;

    logic              valid_reg;
    logic [ADDR_W-1:0] prefix_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ADDR_W-1:0] hop_reg;
    logic [PORT_W-1:0] port_reg;
    logic              sel;
    logic              match;
    logic              take;
    search_t           srch_next;
    search_t           srch_reg;

    assign sel = wr.en && (wr.index == cell_index);

    // Track whether this cell holds a live entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Store the entry on an insert aimed at this cell
    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            prefix_reg <= wr.prefix;
            mask_reg   <= wr.mask;
            len_reg    <= wr.len;
            hop_reg    <= wr.hop;
            port_reg   <= wr.port;
        end
    end

    // Compare masked address; replace best only on a strictly longer mask
    assign match = valid_reg && (((srch_in.addr ^ prefix_reg) & mask_reg) == '0);
    assign take  = srch_in.vld && match && (!srch_in.found || (len_reg > srch_in.len));

    always_comb
    begin
        srch_next = srch_in;
        if (take)
        begin
            srch_next.found = 1'b1;
            srch_next.len   = len_reg;
            srch_next.hop   = hop_reg;
            srch_next.port  = port_reg;
            srch_next.mask  = mask_reg;
        end
    end

    // Hand the beat to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            srch_reg <= '0;
        end
        else
        begin
            srch_reg <= srch_next;
        end
    end

    assign srch_out = srch_reg;

endmodule

### rtl/longest_prefix_route_lookup_core.sv
// Top level: route table as a chain of cells with request control and result register.
// Lookup: the search beat leaves the inject register and crosses one cell per cycle down
//   the chain into the result register. Insert, clear: result goes straight to that register.
// One item at a time: next item accepted once the previous result sits in the output
//   register, which takes it from the result register once it is free.
// Reset (rst_n, async, active low) empties the table and the output register.
module longest_prefix_route_lookup_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [lprl_pkg::ADDR_W-1:0]  address,
    input  logic [lprl_pkg::ADDR_W-1:0]  prefix_mask,
    input  logic [lprl_pkg::ADDR_W-1:0]  hop_address,
    input  logic [lprl_pkg::PORT_W-1:0]  port_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   status,
    output logic [lprl_pkg::ADDR_W-1:0]  found_hop,
    output logic [lprl_pkg::PORT_W-1:0]  found_port,
    output logic [lprl_pkg::ADDR_W-1:0]  found_mask
);
    import lprl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    search_t           inj_reg;
    logic [2:0]        res_status_reg;
    logic [ADDR_W-1:0] res_hop_reg;
    logic [PORT_W-1:0] res_port_reg;
    logic [ADDR_W-1:0] res_mask_reg;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [ADDR_W-1:0] out_hop_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic [ADDR_W-1:0] out_mask_reg;

    logic              accept;
    logic              full;
    logic              out_free;
    logic              out_load;
    logic [LEN_W-1:0]  mask_len;
    wr_t               wr_bus;
    search_t           link [0:TABLE_DEPTH];

    // Count mask ones with an adder tree
    function automatic logic [LEN_W-1:0] ones32(input logic [ADDR_W-1:0] v);
        logic [1:0] l1 [0:15];
        logic [2:0] l2 [0:7];
        logic [3:0] l3 [0:3];
        logic [4:0] l4 [0:1];
        for (int i = 0; i < 16; i++)
        begin
            l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        return LEN_W'({1'b0, l4[0]} + {1'b0, l4[1]});
    endfunction

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_FINISH) && out_free;
    assign mask_len = ones32(prefix_mask);

    // Broadcast insert and clear to the cells
    always_comb
    begin
        wr_bus.en     = accept && (mode == MODE_INSERT) && !full;
        wr_bus.clear  = accept && (mode == MODE_CLEAR);
        wr_bus.index  = count_reg[IDX_W-1:0];
        wr_bus.prefix = address;
        wr_bus.mask   = prefix_mask;
        wr_bus.len    = mask_len;
        wr_bus.hop    = hop_address;
        wr_bus.port   = port_number;
    end

    // Cell chain
    assign link[0] = inj_reg;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            lprl_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_index (IDX_W'(g)),
                .wr         (wr_bus),
                .srch_in    (link[g]),
                .srch_out   (link[g+1])
            );
        end
    endgenerate

    // Sequence requests, count entries, hold results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            inj_reg        <= '0;
            res_status_reg <= ST_MISS;
            res_hop_reg    <= '0;
            res_port_reg   <= '0;
            res_mask_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_MISS;
            out_hop_reg    <= '0;
            out_port_reg   <= '0;
            out_mask_reg   <= '0;
        end
        else
        begin
            // Launch a search beat only for an accepted lookup
            inj_reg.vld <= accept && (mode == MODE_LOOKUP);

            // Raise valid on a load, drop it once the beat is taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_hop_reg  <= '0;
                        res_port_reg <= '0;
                        res_mask_reg <= '0;
                        case (mode)
                            MODE_LOOKUP:
                            begin
                                inj_reg.addr  <= address;
                                inj_reg.found <= 1'b0;
                                inj_reg.len   <= '0;
                                inj_reg.hop   <= '0;
                                inj_reg.port  <= '0;
                                inj_reg.mask  <= '0;
                                state_reg     <= S_SEARCH;
                            end
                            MODE_INSERT:
                            begin
                                state_reg <= S_FINISH;
                                if (full)
                                begin
                                    res_status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    res_status_reg <= ST_INSERTED;
                                    count_reg      <= count_reg + CNT_W'(1);
                                end
                            end
                            MODE_CLEAR:
                            begin
                                res_status_reg <= ST_CLEARED;
                                count_reg      <= '0;
                                state_reg      <= S_FINISH;
                            end
                            default:
                            begin
                                res_status_reg <= ST_MISS;
                                state_reg      <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    // Catch the beat leaving the last cell
                    if (link[TABLE_DEPTH].vld)
                    begin
                        if (link[TABLE_DEPTH].found)
                        begin
                            res_status_reg <= ST_HIT;
                            res_hop_reg    <= link[TABLE_DEPTH].hop;
                            res_port_reg   <= link[TABLE_DEPTH].port;
                            res_mask_reg   <= link[TABLE_DEPTH].mask;
                        end
                        else
                        begin
                            res_status_reg <= ST_MISS;
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    // Move result into the output register once it is free
                    if (out_free)
                    begin
                        out_status_reg <= res_status_reg;
                        out_hop_reg    <= res_hop_reg;
                        out_port_reg   <= res_port_reg;
                        out_mask_reg   <= res_mask_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign found_hop  = out_hop_reg;
    assign found_port = out_port_reg;
    assign found_mask = out_mask_reg;

endmodule

### tb/sv/tb_longest_prefix_route_lookup_core.sv
// Testbench for the longest-prefix route lookup core: directed and random traffic checked against a table predictor.
`timescale 1ns / 1ps

module tb_longest_prefix_route_lookup_core;
    import lprl_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES = TABLE_DEPTH + 8;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] hop;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] mask;
    } route_answer_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] prefix_mask;
    logic [ADDR_W-1:0] hop_address;
    logic [PORT_W-1:0] port_number;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [ADDR_W-1:0] found_hop;
    logic [PORT_W-1:0] found_port;
    logic [ADDR_W-1:0] found_mask;

    // Predicted route table
    logic              tbl_valid  [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_prefix [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_mask   [TABLE_DEPTH];
    logic [ADDR_W-1:0] tbl_hop    [TABLE_DEPTH];
    logic [PORT_W-1:0] tbl_port   [TABLE_DEPTH];
    int                tbl_count;

    route_answer_t route_answers_due[$];

    bit calm_traffic;
    int hold_off_request;
    int cycles;
    int n_errors, n_checked;
    int n_lookup, n_hit, n_insert, n_full, n_clear, n_unused;

    longest_prefix_route_lookup_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .address     (address),
        .prefix_mask (prefix_mask),
        .hop_address (hop_address),
        .port_number (port_number),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_hop   (found_hop),
        .found_port  (found_port),
        .found_mask  (found_mask)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Contiguous network mask of the given length
    function automatic logic [ADDR_W-1:0] route_mask(input int len);
        return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
    endfunction

    // Compute the answer for one operation and advance the predicted table
    function automatic route_answer_t route_table_answer(input logic [1:0] op,
                                                         input logic [ADDR_W-1:0] addr,
                                                         input logic [ADDR_W-1:0] mask,
                                                         input logic [ADDR_W-1:0] hop,
                                                         input logic [PORT_W-1:0] port);
        route_answer_t ans;
        bit            found;
        int            best_len;
        ans        = '0;
        ans.status = ST_MISS;
        found      = 1'b0;
        best_len   = 0;
        case (op)
            MODE_LOOKUP:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    if (tbl_valid[i] && ((addr & tbl_mask[i]) == (tbl_prefix[i] & tbl_mask[i]))
                        && (!found || $countones(tbl_mask[i]) > best_len))
                    begin
                        found    = 1'b1;
                        best_len = $countones(tbl_mask[i]);
                        ans.hop  = tbl_hop[i];
                        ans.port = tbl_port[i];
                        ans.mask = tbl_mask[i];
                    end
                end
                ans.status = found ? ST_HIT : ST_MISS;
            end
            MODE_INSERT:
            begin
                if (tbl_count >= TABLE_DEPTH)
                    ans.status = ST_FULL;
                else
                begin
                    tbl_valid[tbl_count]  = 1'b1;
                    tbl_prefix[tbl_count] = addr;
                    tbl_mask[tbl_count]   = mask;
                    tbl_hop[tbl_count]    = hop;
                    tbl_port[tbl_count]   = port;
                    tbl_count++;
                    ans.status = ST_INSERTED;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    tbl_valid[i] = 1'b0;
                tbl_count  = 0;
                ans.status = ST_CLEARED;
            end
            default: ;
        endcase
        return ans;
    endfunction

    // Mostly short gaps, a few long ones, none while traffic is calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_traffic || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one beat and wait for its acceptance, then record the predicted answer
    task automatic send_route_op(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                 input logic [ADDR_W-1:0] mask, input logic [ADDR_W-1:0] hop,
                                 input logic [PORT_W-1:0] port);
        int            gap;
        route_answer_t ans;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        address     <= addr;
        prefix_mask <= mask;
        hop_address <= hop;
        port_number <= port;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ans = route_table_answer(op, addr, mask, hop, port);
        route_answers_due.push_back(ans);
        case (op)
            MODE_LOOKUP: n_lookup++;
            MODE_INSERT: n_insert++;
            MODE_CLEAR:  n_clear++;
            default:     n_unused++;
        endcase
        if (ans.status == ST_HIT)
            n_hit++;
        if (ans.status == ST_FULL)
            n_full++;
    endtask

    task automatic lookup_at(input logic [ADDR_W-1:0] addr);
        send_route_op(MODE_LOOKUP, addr, $urandom, $urandom, PORT_W'($urandom));
    endtask

    task automatic insert_route(input logic [ADDR_W-1:0] prefix, input logic [ADDR_W-1:0] mask,
                                input logic [ADDR_W-1:0] hop, input logic [PORT_W-1:0] port);
        send_route_op(MODE_INSERT, prefix, mask, hop, port);
    endtask

    // Drop valid and hold the sender until every result is back
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (route_answers_due.size() == 0);
    endtask

    // Random route: fresh, nested under a stored one, a duplicate, or an odd mask
    task automatic insert_random_route();
        logic [ADDR_W-1:0] prefix, mask;
        int                r, k;
        r = $urandom_range(0, 99);
        prefix = $urandom;
        mask   = route_mask($urandom_range(0, 32));
        if (r < 10)
            mask = $urandom;
        else if (tbl_count > 0 && r < 60)
        begin
            k      = $urandom_range(0, tbl_count - 1);
            prefix = (tbl_prefix[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
            mask   = (r < 20) ? tbl_mask[k] : (tbl_mask[k] | mask);
        end
        insert_route(prefix, mask, $urandom, PORT_W'($urandom));
    endtask

    // Random destination, mostly inside a stored route
    task automatic lookup_random();
        logic [ADDR_W-1:0] addr;
        int                r, k;
        r    = $urandom_range(0, 99);
        addr = $urandom;
        if (r < 4)
            addr = '0;
        else if (r < 8)
            addr = '1;
        else if (tbl_count > 0 && r < 80)
        begin
            k    = $urandom_range(0, tbl_count - 1);
            addr = (tbl_prefix[k] & tbl_mask[k]) | ($urandom & ~tbl_mask[k]);
        end
        lookup_at(addr);
    endtask

    // Empty table, every mode, mask lengths, ties, odd masks and extremes
    task automatic test_directed();
        lookup_at(32'h0000_0000);
        lookup_at(32'hFFFF_FFFF);
        send_route_op(MODE_UNUSED, '1, '1, '1, '1);
        send_route_op(MODE_CLEAR, '0, '0, '0, '0);
        // default route whose prefix carries bits outside the mask
        insert_route(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 8'd0);
        lookup_at(32'h1234_5678);
        insert_route(32'h0A00_0000, route_mask(8), 32'h0A00_0001, 8'd1);
        insert_route(32'h0A01_0000, route_mask(16), 32'h0A01_0001, 8'd2);
        insert_route(32'h0A01_02FF, route_mask(24), 32'h0A01_0201, 8'd3);
        insert_route(32'h0A01_0203, route_mask(32), 32'hFFFF_FFFF, 8'd255);
        lookup_at(32'h0A01_0203);
        lookup_at(32'h0A01_0204);
        lookup_at(32'h0A01_0909);
        lookup_at(32'h0AC8_0001);
        lookup_at(32'h0B00_0000);
        // duplicate route: the earlier entry keeps winning
        insert_route(32'h0A01_0000, route_mask(16), 32'h0A01_0099, 8'd4);
        lookup_at(32'h0A01_4D01);
        // mask with holes
        insert_route(32'hC000_A800, 32'hFF00_FF00, 32'hC0A8_0001, 8'd5);
        lookup_at(32'hC012_A834);
        insert_route(32'h8000_0000, 32'h8000_0000, 32'h8000_0001, 8'd6);
        lookup_at(32'h9000_0000);
        insert_route(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'hA5);
        lookup_at(32'hFFFF_FFFF);
        send_route_op(MODE_UNUSED, 32'h0A01_0203, '0, '0, '0);
        lookup_at(32'h0A01_0203);
        send_route_op(MODE_CLEAR, '1, '1, '1, '1);
        lookup_at(32'h0A01_0203);
    endtask

    // Fill every entry, then insert into the full table
    task automatic test_table_full();
        send_route_op(MODE_CLEAR, $urandom, $urandom, $urandom, PORT_W'($urandom));
        repeat (TABLE_DEPTH)
            insert_random_route();
        repeat (3)
            insert_random_route();
        repeat (6)
            lookup_random();
        send_route_op(MODE_CLEAR, '0, '0, '0, '0);
        lookup_random();
    endtask

    // Hold off the receiver while the sender keeps offering beats
    task automatic test_output_stall();
        insert_route(32'hAC10_0000, route_mask(12), 32'hAC10_0001, 8'd7);
        wait_for_results();
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (3)
            lookup_random();
        insert_random_route();
        lookup_random();
        wait_for_results();
    endtask

    // Phases of clear, inserts and lookups with random content and some noise
    task automatic test_random_traffic(input int n_items);
        int start, n_routes, n_lookups, r;
        start = n_lookup + n_insert + n_clear + n_unused;
        while (n_lookup + n_insert + n_clear + n_unused - start < n_items)
        begin
            calm_traffic = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
            send_route_op(MODE_CLEAR, $urandom, $urandom, $urandom, PORT_W'($urandom));
            n_routes  = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                      : $urandom_range(1, 12);
            n_lookups = $urandom_range(4, 20);
            repeat (n_routes)
                insert_random_route();
            repeat (n_lookups)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_route_op(MODE_UNUSED, $urandom, $urandom, $urandom,
                                  PORT_W'($urandom));
                else if (r < 9)
                    send_route_op(MODE_CLEAR, $urandom, $urandom, $urandom,
                                  PORT_W'($urandom));
                else if (r < 18)
                    insert_random_route();
                else
                    lookup_random();
            end
        end
        calm_traffic = 1'b0;
    endtask

    // Compare one result field and report a mismatch
    task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Check every result beat against the oldest predicted answer
    always @(posedge clk)
    begin : result_check
        route_answer_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (route_answers_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, status);
                n_errors++;
            end
            else
            begin
                want = route_answers_due.pop_front();
                check_field("status", ADDR_W'(want.status), ADDR_W'(status));
                check_field("found_hop", want.hop, found_hop);
                check_field("found_port", ADDR_W'(want.port), ADDR_W'(found_port));
                check_field("found_mask", want.mask, found_mask);
                n_checked++;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial
    begin : result_sink
        int stall_left, hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ready  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (!calm_traffic && $urandom_range(0, 99) < 25)
            begin
                stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(10, 50);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // End the run if it hangs
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        mode             = MODE_LOOKUP;
        address          = '0;
        prefix_mask      = '0;
        hop_address      = '0;
        port_number      = '0;
        calm_traffic     = 1'b0;
        hold_off_request = 0;
        tbl_count        = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_output_stall();
        test_random_traffic(340);

        // Drain and let the block settle
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (route_answers_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, route_answers_due.size());
            n_errors++;
        end

        $display("Sent %0d lookups (%0d hits), %0d inserts (%0d into a full table),",
                 n_lookup, n_hit, n_insert, n_full);
        $display("%0d clears and %0d unused-mode beats; checked %0d results, %0d errors.",
                 n_clear, n_unused, n_checked, n_errors);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/lprl_pkg.sv
rtl/lprl_cell.sv
rtl/longest_prefix_route_lookup_core.sv
tb/sv/tb_longest_prefix_route_lookup_core.sv
